### rtl/core/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types, codes and byte constants of the boot catalog analyzer.
// ----------------------------------------------------------------------------
package bca_pkg;

   localparam int unsigned SectorBytesDefault = 512;
   localparam int unsigned EntryBytes         = 32;
   localparam int unsigned EntryOffWidth      = $clog2(EntryBytes);

   // Catalog byte values.
   localparam logic [7:0] HeaderValidation = 8'h01;
   localparam logic [7:0] PlatformX86      = 8'h00;
   localparam logic [7:0] PlatformEfi      = 8'hEF;
   localparam logic [7:0] SectionMore      = 8'h90;
   localparam logic [7:0] SectionFinal     = 8'h91;
   localparam logic [7:0] BootBootable     = 8'h88;
   localparam logic [7:0] MediaHardDisk    = 8'h04;
   localparam logic [7:0] KeyFirst         = 8'h55;
   localparam logic [7:0] KeySecond        = 8'hAA;
   localparam logic [7:0] PartFat16Small   = 8'h04;
   localparam logic [7:0] PartFat16        = 8'h06;
   localparam logic [7:0] PartFat32        = 8'h0B;
   localparam logic [7:0] PartFat32Lba     = 8'h0C;

   // Fixed byte offsets inside the catalog.
   localparam int unsigned OffHeader    = 0;
   localparam int unsigned OffPlatform  = 1;
   localparam int unsigned OffKeyFirst  = 30;
   localparam int unsigned OffKeySecond = 31;
   localparam int unsigned OffBoot      = 32;
   localparam int unsigned OffMedia     = 33;
   localparam int unsigned OffPart      = 36;
   localparam int unsigned OffRbaFirst  = 40;
   localparam int unsigned OffRbaLast   = 43;
   localparam int unsigned OffSections  = 64;

   typedef enum logic [2:0] {
      REASON_NONE       = 3'd0,
      REASON_VALID_EFI  = 3'd1,
      REASON_SECT_EFI   = 3'd2,
      REASON_SECT_X86   = 3'd3,
      REASON_DISK_IMAGE = 3'd4
   } reason_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        efi_found;
      logic [2:0]  efi_reason;
      logic        bios_entry_valid;
      logic [31:0] bios_load_rba;
   } rsp_payload_type;

   // Catalog fields gathered so far.
   typedef struct packed {
      logic [7:0]  header_id;
      logic [7:0]  platform_id;
      logic        key_ok;
      logic [7:0]  boot_indicator;
      logic [7:0]  media_type;
      logic [7:0]  partition_type;
      logic [31:0] load_rba;
      reason_type  found_reason;
   } cat_state_type;

   function automatic logic is_fat_type(input logic [7:0] t);
      return (t == PartFat16Small) || (t == PartFat16) ||
             (t == PartFat32) || (t == PartFat32Lba);
   endfunction

   function automatic logic is_x86_validation(input cat_state_type s);
      return (s.header_id == HeaderValidation) && (s.platform_id == PlatformX86);
   endfunction

endpackage

### rtl/core/bca_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_req_if / bca_rsp_if
// Valid/ready channels for catalog bytes in and analysis results out.
// ----------------------------------------------------------------------------
interface bca_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bca_rsp_if;
   logic        valid;
   logic        ready;
   logic        efi_found;
   logic [2:0]  efi_reason;
   logic        bios_entry_valid;
   logic [31:0] bios_load_rba;

   modport source (output valid, output efi_found, output efi_reason,
                   output bios_entry_valid, output bios_load_rba, input ready);
   modport sink   (input valid, input efi_found, input efi_reason,
                   input bios_entry_valid, input bios_load_rba, output ready);
endinterface

### rtl/core/boot_catalog_analyzer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_catalog_analyzer
// Streams an El Torito boot catalog sector and reports EFI and BIOS entries.
// ----------------------------------------------------------------------------
// One catalog byte is taken per clock; each request updates the captured
// fields in the same cycle, and the request marked last loads the result
// register, which appears on the response channel in the next cycle. The result
// register is the only buffer: while a result waits and the response side is
// not ready, requests are held off until it drains. Bytes beyond SECTOR_BYTES
// are ignored, and the analyzer starts a fresh sector at offset 0 right after
// each last byte.
module boot_catalog_analyzer #(
   parameter int unsigned SECTOR_BYTES = bca_pkg::SectorBytesDefault
) (
   input  logic      clock,
   input  logic      reset,
   bca_req_if.sink   req_if,
   bca_rsp_if.source rsp_if
);
   import bca_pkg::*;

   logic            accept;
   logic            req_ready;
   req_payload_type req;
   cat_state_type   cat_view;

   assign req.data_byte = req_if.data_byte;
   assign req.last_byte = req_if.last_byte;
   assign req_if.ready  = req_ready;
   assign accept        = req_if.valid && req_ready;

   bca_capture #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_capture (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .cat_view (cat_view)
   );

   bca_result u_result (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .last_byte (req.last_byte),
      .cat_view  (cat_view),
      .req_ready (req_ready),
      .rsp_if    (rsp_if)
   );

endmodule

### rtl/core/bca_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_capture
// Tracks the byte position and captures the catalog fields and rule hits.
// ----------------------------------------------------------------------------
module bca_capture #(
   parameter int unsigned SECTOR_BYTES = bca_pkg::SectorBytesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  bca_pkg::req_payload_type req,
   output bca_pkg::cat_state_type cat_view
);
   import bca_pkg::*;

   localparam int unsigned PosWidth = $clog2(SECTOR_BYTES + 1);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]          efb_ff, efb_in, efb_take;
   cat_state_type       st_ff, st_in, take;
   logic                in_sector;
   logic                section_pos;
   logic [EntryOffWidth-1:0] entry_off;

   assign in_sector   = pos_ff < PosWidth'(SECTOR_BYTES);
   assign entry_off   = pos_ff[EntryOffWidth-1:0];
   assign section_pos = pos_ff >= PosWidth'(OffSections);

   // Field state after the current byte, before the end-of-sector clear.
   always_comb begin
      take     = st_ff;
      efb_take = efb_ff;
      if (accept && in_sector) begin
         if (pos_ff == PosWidth'(OffHeader)) begin
            take.header_id = req.data_byte;
         end else if (pos_ff == PosWidth'(OffPlatform)) begin
            take.platform_id = req.data_byte;
            if (st_ff.header_id == HeaderValidation && req.data_byte == PlatformEfi &&
                st_ff.found_reason == REASON_NONE) begin
               take.found_reason = REASON_VALID_EFI;
            end
         end else if (pos_ff == PosWidth'(OffKeyFirst)) begin
            take.key_ok = (req.data_byte == KeyFirst);
         end else if (pos_ff == PosWidth'(OffKeySecond)) begin
            take.key_ok = st_ff.key_ok && (req.data_byte == KeySecond);
         end else if (pos_ff == PosWidth'(OffBoot)) begin
            take.boot_indicator = req.data_byte;
         end else if (pos_ff == PosWidth'(OffMedia)) begin
            take.media_type = req.data_byte;
         end else if (pos_ff == PosWidth'(OffPart)) begin
            take.partition_type = req.data_byte;
         end else if (pos_ff >= PosWidth'(OffRbaFirst) && pos_ff <= PosWidth'(OffRbaLast)) begin
            // The RBA starts on a 4-byte boundary, so the low bits pick the lane.
            take.load_rba[pos_ff[1:0]*8 +: 8] = req.data_byte;
         end

         if (section_pos) begin
            if (entry_off == '0) begin
               efb_take = req.data_byte;
            end else if (entry_off == EntryOffWidth'(1) &&
                         st_ff.found_reason == REASON_NONE &&
                         (efb_ff == SectionMore || efb_ff == SectionFinal)) begin
               if (req.data_byte == PlatformEfi) begin
                  take.found_reason = REASON_SECT_EFI;
               end else if (req.data_byte == PlatformX86 && is_x86_validation(st_ff)) begin
                  take.found_reason = REASON_SECT_X86;
               end
            end
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      st_in  = take;
      efb_in = efb_take;
      if (accept && in_sector) begin
         pos_in = pos_ff + PosWidth'(1);
      end
      if (accept && req.last_byte) begin
         pos_in = '0;
         st_in  = '0;
         efb_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         st_ff  <= '0;
         efb_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         st_ff  <= st_in;
         efb_ff <= efb_in;
      end
   end

   assign cat_view = take;

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req.last_byte |=> pos_ff == '0 && st_ff.found_reason == REASON_NONE)
      else $error("sector state not cleared after last byte");

   a_reason_sticks: assert property (@(posedge clock) disable iff (reset)
      st_ff.found_reason != REASON_NONE && !(accept && req.last_byte)
      |=> st_ff.found_reason == $past(st_ff.found_reason))
      else $error("matched rule changed within a sector");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosWidth'(SECTOR_BYTES))
      else $error("byte position ran past the sector");

endmodule

### rtl/core/bca_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_result
// Applies the disk image rule and the BIOS entry check, holds the result.
// ----------------------------------------------------------------------------
module bca_result (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   last_byte,
   input  bca_pkg::cat_state_type cat_view,
   output logic                   req_ready,
   bca_rsp_if.source              rsp_if
);
   import bca_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   reason_type      reason;
   logic            bios_ok;

   always_comb begin
      reason = cat_view.found_reason;
      if (reason == REASON_NONE && is_x86_validation(cat_view) &&
          cat_view.boot_indicator == BootBootable &&
          cat_view.media_type == MediaHardDisk && is_fat_type(cat_view.partition_type)) begin
         reason = REASON_DISK_IMAGE;
      end
      bios_ok = is_x86_validation(cat_view) && cat_view.key_ok &&
                cat_view.boot_indicator == BootBootable;

      rsp_in.efi_found        = (reason != REASON_NONE);
      rsp_in.efi_reason       = reason;
      rsp_in.bios_entry_valid = bios_ok;
      rsp_in.bios_load_rba    = bios_ok ? cat_view.load_rba : 32'd0;
   end

   // A new request is taken whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (accept && last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.efi_found        = rsp_ff.efi_found;
   assign rsp_if.efi_reason       = rsp_ff.efi_reason;
   assign rsp_if.bios_entry_valid = rsp_ff.bios_entry_valid;
   assign rsp_if.bios_load_rba    = rsp_ff.bios_load_rba;

   a_found_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.efi_found == (rsp_ff.efi_reason != REASON_NONE))
      else $error("efi_found disagrees with efi_reason");

   a_rba_zero_if_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.bios_entry_valid |-> rsp_ff.bios_load_rba == 32'd0)
      else $error("load RBA reported for an invalid BIOS entry");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff || rsp_if.ready)
      else $error("request accepted while result register is blocked");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for boot_catalog_analyzer: catalog sectors are streamed
// byte by byte and every analysis report is compared with a local predictor.
// ----------------------------------------------------------------------------
// A table of hand-built sectors comes first, then random sectors that are
// mostly shaped like real boot catalogs, sent in three phases: two with
// random sender and receiver idling, one without. A long response stall
// and a full drain of the pending reports are forced along the way.
module tb;
   import bca_pkg::*;

   localparam int unsigned SectorLen     = SectorBytesDefault;
   localparam int unsigned BufLen        = 640;
   localparam int          PhaseBytes    = 60;
   localparam int          PhaseReports  = 3;
   localparam int          HoldCycles    = 300;
   localparam int          CycleLimit    = 500000;
   localparam int          DirRows       = 18;
   localparam logic [19:0] NoPatch       = 20'd0;

   // One hand-built sector: length, filler byte, up to six byte overrides
   // and, where it is obvious, the report typed in directly.
   typedef struct packed {
      logic [11:0]      length;
      logic [7:0]       fill;
      logic [5:0][19:0] patches;
      logic             typed;
      rsp_payload_type  want;
   } sector_row_type;

   logic clock;
   logic reset;

   bca_req_if req_ch ();
   bca_rsp_if rsp_ch ();

   boot_catalog_analyzer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predictor state for the sector being received.
   cat_state_type cat;
   int unsigned   cat_pos;
   logic [7:0]    cat_entry_head;

   rsp_payload_type expected_reports[$];
   logic [7:0]      sector_buf[BufLen];
   sector_row_type  dir_table[DirRows];

   int snd_idle_pct  = 0;
   int rcv_idle_pct  = 0;
   bit hold_request  = 1'b0;
   int error_count   = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [19:0] patch_at(input int unsigned off, input logic [7:0] v);
      return {1'b1, off[10:0], v};
   endfunction

   function automatic void catalog_clear();
      cat            = '0;
      cat_pos        = 0;
      cat_entry_head = 8'h00;
   endfunction

   // Absorbs one request; returns 1 and the report when the byte is marked last.
   function automatic bit catalog_step(input logic [7:0] b, input logic last,
                                       output rsp_payload_type r);
      reason_type why;
      logic       x86;
      logic       bios_ok;
      r = '0;
      if (cat_pos < SectorLen) begin
         case (cat_pos)
            OffHeader: cat.header_id = b;
            OffPlatform: begin
               cat.platform_id = b;
               if (cat.header_id == HeaderValidation && b == PlatformEfi &&
                   cat.found_reason == REASON_NONE) begin
                  cat.found_reason = REASON_VALID_EFI;
               end
            end
            OffKeyFirst:  cat.key_ok = (b == KeyFirst);
            OffKeySecond: cat.key_ok = cat.key_ok && (b == KeySecond);
            OffBoot:      cat.boot_indicator = b;
            OffMedia:     cat.media_type = b;
            OffPart:      cat.partition_type = b;
            default: begin
               if (cat_pos >= OffRbaFirst && cat_pos <= OffRbaLast) begin
                  cat.load_rba[8*(cat_pos-OffRbaFirst) +: 8] = b;
               end
            end
         endcase
         if (cat_pos >= OffSections) begin
            if (cat_pos % EntryBytes == 0) begin
               cat_entry_head = b;
            end else if (cat_pos % EntryBytes == 1 && cat.found_reason == REASON_NONE &&
                         (cat_entry_head == SectionMore ||
                          cat_entry_head == SectionFinal)) begin
               if (b == PlatformEfi) begin
                  cat.found_reason = REASON_SECT_EFI;
               end else if (b == PlatformX86 && cat.header_id == HeaderValidation &&
                            cat.platform_id == PlatformX86) begin
                  cat.found_reason = REASON_SECT_X86;
               end
            end
         end
         cat_pos++;
      end
      if (!last) return 1'b0;

      x86 = (cat.header_id == HeaderValidation) && (cat.platform_id == PlatformX86);
      why = cat.found_reason;
      if (why == REASON_NONE && x86 && cat.boot_indicator == BootBootable &&
          cat.media_type == MediaHardDisk &&
          (cat.partition_type == PartFat16Small || cat.partition_type == PartFat16 ||
           cat.partition_type == PartFat32 || cat.partition_type == PartFat32Lba)) begin
         why = REASON_DISK_IMAGE;
      end
      bios_ok            = x86 && cat.key_ok && (cat.boot_indicator == BootBootable);
      r.efi_found        = (why != REASON_NONE);
      r.efi_reason       = why;
      r.bios_entry_valid = bios_ok;
      r.bios_load_rba    = bios_ok ? cat.load_rba : 32'd0;
      catalog_clear();
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input rsp_payload_type want);
      rsp_payload_type r;
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (catalog_step(b, last, r)) begin
         expected_reports.push_back(typed ? want : r);
      end
   endtask

   task automatic send_sector(input int len, input logic typed, input rsp_payload_type want);
      for (int i = 0; i < len; i++) begin
         send_byte(sector_buf[i], (i == len - 1), typed, want);
      end
   endtask

   task automatic wait_reports_drained();
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // Random sector, mostly laid out like a real catalog with random content.
   task automatic build_random_sector(output int len);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 40);
      else if (pick < 95) len = $urandom_range(41, 100);
      else if (pick < 98) len = $urandom_range(101, SectorLen - 1);
      else                len = $urandom_range(SectorLen, 600);
      for (int i = 0; i < BufLen; i++) sector_buf[i] = 8'($urandom);
      if ($urandom_range(0, 99) < 15) return;

      sector_buf[OffHeader] = ($urandom_range(0, 99) < 80) ? HeaderValidation : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55)      sector_buf[OffPlatform] = PlatformX86;
      else if (pick < 80) sector_buf[OffPlatform] = PlatformEfi;
      if ($urandom_range(0, 99) < 75) sector_buf[OffKeyFirst]  = KeyFirst;
      if ($urandom_range(0, 99) < 75) sector_buf[OffKeySecond] = KeySecond;
      if ($urandom_range(0, 99) < 70) sector_buf[OffBoot]      = BootBootable;
      if ($urandom_range(0, 99) < 60) sector_buf[OffMedia]     = MediaHardDisk;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: sector_buf[OffPart] = PartFat16Small;
         2, 3: sector_buf[OffPart] = PartFat16;
         4:    sector_buf[OffPart] = PartFat32;
         5, 6: sector_buf[OffPart] = PartFat32Lba;
         default: ;
      endcase
      for (int o = OffSections; o + 1 < BufLen; o += EntryBytes) begin
         if ($urandom_range(0, 99) < 12) begin
            sector_buf[o] = $urandom_range(0, 1) ? SectionMore : SectionFinal;
            pick = $urandom_range(0, 9);
            if (pick < 4)      sector_buf[o+1] = PlatformEfi;
            else if (pick < 8) sector_buf[o+1] = PlatformX86;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            error_count++;
            $display("%0t: report with none expected, actual found=%0d reason=%0d %s",
                     $time, rsp_ch.efi_found, rsp_ch.efi_reason,
                     $sformatf("valid=%0d rba=0x%0h", rsp_ch.bios_entry_valid,
                               rsp_ch.bios_load_rba));
         end else begin
            want = expected_reports.pop_front();
            check_field("efi_found", 32'(want.efi_found), 32'(rsp_ch.efi_found));
            check_field("efi_reason", 32'(want.efi_reason), 32'(rsp_ch.efi_reason));
            check_field("bios_entry_valid", 32'(want.bios_entry_valid),
                        32'(rsp_ch.bios_entry_valid));
            check_field("bios_load_rba", want.bios_load_rba, rsp_ch.bios_load_rba);
         end
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   initial begin
      sector_row_type  row;
      rsp_payload_type none_want;
      int              len;
      int              phase_bytes;
      int              phase_reports;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      none_want        = '0;
      catalog_clear();

      dir_table = '{
         // One-byte sector: nothing gathered.
         '{12'd1, 8'hFF, {6{NoPatch}}, 1'b1, {1'b0, REASON_NONE, 1'b0, 32'd0}},
         // EFI validation entry.
         '{12'd2, 8'h00, {patch_at(0, 8'h01), patch_at(1, 8'hEF), {4{NoPatch}}},
           1'b1, {1'b1, REASON_VALID_EFI, 1'b0, 32'd0}},
         // Valid BIOS default entry with an all-ones load RBA.
         '{12'd44, 8'hFF, {patch_at(0, 8'h01), patch_at(1, 8'h00), patch_at(30, 8'h55),
           patch_at(31, 8'hAA), patch_at(32, 8'h88), NoPatch},
           1'b1, {1'b0, REASON_NONE, 1'b1, 32'hFFFF_FFFF}},
         '{12'd44, 8'h00, {patch_at(0, 8'h01), patch_at(30, 8'h55), patch_at(31, 8'hAA),
           patch_at(32, 8'h88), patch_at(40, 8'h78), patch_at(43, 8'h12)},
           1'b1, {1'b0, REASON_NONE, 1'b1, 32'h1200_0078}},
         // Hard-disk image with FAT32 LBA, but no 55AA key.
         '{12'd37, 8'h00, {patch_at(0, 8'h01), patch_at(32, 8'h88), patch_at(33, 8'h04),
           patch_at(36, 8'h0C), {2{NoPatch}}}, 1'b1, {1'b1, REASON_DISK_IMAGE, 1'b0, 32'd0}},
         '{12'd37, 8'h00, {patch_at(0, 8'h01), patch_at(32, 8'h88), patch_at(33, 8'h04),
           patch_at(36, 8'h04), {2{NoPatch}}}, 1'b0, none_want},
         '{12'd44, 8'h00, {patch_at(0, 8'h01), patch_at(30, 8'h55), patch_at(31, 8'hAA),
           patch_at(32, 8'h88), patch_at(33, 8'h04), patch_at(36, 8'h06)}, 1'b0, none_want},
         // EFI validation wins over a disk image.
         '{12'd44, 8'h00, {patch_at(0, 8'h01), patch_at(1, 8'hEF), patch_at(32, 8'h88),
           patch_at(33, 8'h04), patch_at(36, 8'h0B), NoPatch}, 1'b0, none_want},
         // First section header with EFI platform.
         '{12'd66, 8'h00, {patch_at(64, 8'h90), patch_at(65, 8'hEF), {4{NoPatch}}},
           1'b1, {1'b1, REASON_SECT_EFI, 1'b0, 32'd0}},
         // Second section header, x86 platform after an x86 validation entry.
         '{12'd98, 8'h00, {patch_at(0, 8'h01), patch_at(96, 8'h91), patch_at(97, 8'h00),
           {3{NoPatch}}}, 1'b1, {1'b1, REASON_SECT_X86, 1'b0, 32'd0}},
         // x86 section platform without an x86 validation entry.
         '{12'd66, 8'h00, {patch_at(64, 8'h91), patch_at(65, 8'h00), {4{NoPatch}}},
           1'b0, none_want},
         // Section header whose platform byte never arrives.
         '{12'd65, 8'h00, {patch_at(0, 8'h01), patch_at(64, 8'h90), {4{NoPatch}}},
           1'b1, {1'b0, REASON_NONE, 1'b0, 32'd0}},
         // Misaligned and too-early section headers do not count.
         '{12'd67, 8'h00, {patch_at(65, 8'h90), patch_at(66, 8'hEF), {4{NoPatch}}},
           1'b0, none_want},
         '{12'd34, 8'h00, {patch_at(32, 8'h90), patch_at(33, 8'hEF), {4{NoPatch}}},
           1'b0, none_want},
         // Bytes past the end of the sector are ignored, even a section header.
         '{12'd514, 8'h00, {patch_at(480, 8'h91), patch_at(481, 8'h11), patch_at(512, 8'h90),
           patch_at(513, 8'hEF), {2{NoPatch}}}, 1'b0, none_want},
         // Final section header with EFI platform.
         '{12'd66, 8'h00, {patch_at(64, 8'h91), patch_at(65, 8'hEF), {4{NoPatch}}},
           1'b0, none_want},
         // Sector ends before the load RBA arrives.
         '{12'd34, 8'hFF, {patch_at(0, 8'h01), patch_at(1, 8'h00), patch_at(30, 8'h55),
           patch_at(31, 8'hAA), patch_at(32, 8'h88), patch_at(33, 8'h04)}, 1'b0, none_want},
         '{12'd66, 8'h00, {patch_at(0, 8'h01), patch_at(1, 8'hEF), patch_at(64, 8'h90),
           patch_at(65, 8'hEF), {2{NoPatch}}}, 1'b0, none_want}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[r]) begin
         row = dir_table[r];
         for (int i = 0; i < row.length; i++) sector_buf[i] = row.fill;
         for (int j = 0; j < 6; j++) begin
            if (row.patches[j][19]) sector_buf[row.patches[j][18:8]] = row.patches[j][7:0];
         end
         send_sector(row.length, row.typed, row.want);
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_reports_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin snd_idle_pct = 38; rcv_idle_pct = 52; end
            1: begin snd_idle_pct = 52; rcv_idle_pct = 38; end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         phase_bytes   = 0;
         phase_reports = 0;
         if (phase == 2) begin
            // Short sectors against a stalled response side fill the block up.
            hold_request = 1'b1;
            for (int k = 0; k < 6; k++) begin
               for (int i = 0; i < 4; i++) sector_buf[i] = 8'($urandom);
               send_sector($urandom_range(1, 4), 1'b0, none_want);
            end
         end
         while (phase_bytes < PhaseBytes || phase_reports < PhaseReports) begin
            build_random_sector(len);
            send_sector(len, 1'b0, none_want);
            phase_bytes   += len;
            phase_reports++;
         end
         @(negedge clock);
         req_ch.valid <= 1'b0;
         wait_reports_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
